/* rtl/core/urb_pkg.sv */
package urb_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int READ_MAX = 64;

	localparam int RX_AW  = $clog2(RX_DEPTH);
	localparam int TX_AW  = $clog2(TX_DEPTH);
	localparam int RX_CW  = $clog2(RX_DEPTH + 1);
	localparam int TX_CW  = $clog2(TX_DEPTH + 1);
	localparam int REM_W  = $clog2(READ_MAX + 1);
	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;
	localparam int RLEN_W = 7;
	localparam int RES_W  = 2;
	localparam int LVL_W  = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_LINE_BYTE = 3'd0,
		KIND_READ_REQ  = 3'd1,
		KIND_WRITE     = 3'd2,
		KIND_TX_READY  = 3'd3,
		KIND_LINE_IDLE = 3'd4
	} kind_t;

	typedef enum logic [RES_W-1:0] {
		RES_TO_SW   = 2'd0,
		RES_TO_LINE = 2'd1,
		RES_ACK     = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_RX   = 2'd1,
		SRC_TX   = 2'd2
	} byte_src_t;

	// one result beat before its data byte is resolved
	typedef struct packed {
		res_kind_t          rkind;
		byte_src_t          src;
		logic               last;
		logic               dropped;
		logic               idle;
		logic [LVL_W-1:0]   rx_level;
		logic [LVL_W-1:0]   tx_level;
		logic               tx_en;
	} res_t;

endpackage

/* rtl/core/urb_out_pipe.sv */
module urb_out_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  urb_pkg::res_t              res,
	input  logic [urb_pkg::BYTE_W-1:0] rx_rdata,
	input  logic [urb_pkg::BYTE_W-1:0] tx_rdata,
	output logic                       slot_free,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [urb_pkg::RES_W-1:0]  result_kind,
	output logic [urb_pkg::BYTE_W-1:0] byte_out,
	output logic                       last,
	output logic                       dropped,
	output logic                       line_idle,
	output logic [urb_pkg::LVL_W-1:0]  rx_level,
	output logic [urb_pkg::LVL_W-1:0]  tx_level,
	output logic                       transmit_enable
);

	logic                       res_valid_s1;
	urb_pkg::res_t              res_s1;
	logic                       s1_move;
	logic [urb_pkg::BYTE_W-1:0] byte_sel;
	logic                       out_valid_q;
	urb_pkg::res_t              out_res_q;
	logic [urb_pkg::BYTE_W-1:0] out_byte_q;

	assign s1_move   = res_valid_s1 && (!out_valid_q || !out_stall);
	assign slot_free = !res_valid_s1 || s1_move;

	// memory read data stays put until the next read, which only issues when s1 is empty or moves
	always_comb begin
		case (res_s1.src)
			urb_pkg::SRC_RX: byte_sel = rx_rdata;
			urb_pkg::SRC_TX: byte_sel = tx_rdata;
			default:         byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load)
				res_valid_s1 <= 1'b1;
			else if (s1_move)
				res_valid_s1 <= 1'b0;
			if (s1_move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s1 <= res;
		if (s1_move) begin
			out_res_q  <= res_s1;
			out_byte_q <= byte_sel;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = out_res_q.rkind;
	assign byte_out        = out_byte_q;
	assign last            = out_res_q.last;
	assign dropped         = out_res_q.dropped;
	assign line_idle       = out_res_q.idle;
	assign rx_level        = out_res_q.rx_level;
	assign tx_level        = out_res_q.tx_level;
	assign transmit_enable = out_res_q.tx_en;

endmodule

/* rtl/core/uart_rx_tx_ring_buffers.sv */
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | kind, data, read_length
// out     | out_valid/out_stall| result_kind, byte_out, last, dropped, line_idle,
//         |                    | rx_level, tx_level, transmit_enable
//
// Single-result items are taken one per cycle while in_stall is low, via s1 and the output
// register. A read request enters the read state, then issues a byte per free s1 slot, one
// receive memory read each; no other item is taken until its last byte is issued.
// Reset clears pointers, fill counts and the enable flag; memory contents are not cleared.
// A stalled output holds one beat and one more waits behind it before input stalls.
module uart_rx_tx_ring_buffers (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [urb_pkg::KIND_W-1:0] kind,
	input  logic [urb_pkg::BYTE_W-1:0] data,
	input  logic [urb_pkg::RLEN_W-1:0] read_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [urb_pkg::RES_W-1:0]  result_kind,
	output logic [urb_pkg::BYTE_W-1:0] byte_out,
	output logic                       last,
	output logic                       dropped,
	output logic                       line_idle,
	output logic [urb_pkg::LVL_W-1:0]  rx_level,
	output logic [urb_pkg::LVL_W-1:0]  tx_level,
	output logic                       transmit_enable
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                     state_q;
	logic [urb_pkg::RX_AW-1:0]  rx_wr_q;
	logic [urb_pkg::RX_AW-1:0]  rx_rd_q;
	logic [urb_pkg::RX_CW-1:0]  rx_fill_q;
	logic [urb_pkg::TX_AW-1:0]  tx_wr_q;
	logic [urb_pkg::TX_AW-1:0]  tx_rd_q;
	logic [urb_pkg::TX_CW-1:0]  tx_fill_q;
	logic                       tx_en_q;
	logic [urb_pkg::REM_W-1:0]  rem_q;

	logic [urb_pkg::BYTE_W-1:0] rx_mem [urb_pkg::RX_DEPTH];
	logic [urb_pkg::BYTE_W-1:0] tx_mem [urb_pkg::TX_DEPTH];
	logic [urb_pkg::BYTE_W-1:0] rx_rdata_q;
	logic [urb_pkg::BYTE_W-1:0] tx_rdata_q;

	logic                       slot_free;
	logic                       accept;
	logic                       rx_push, rx_pop, tx_push, tx_pop;
	logic                       rx_full, rx_empty, tx_full, tx_empty;
	logic                       start_read;
	logic                       read_last;
	logic [urb_pkg::RLEN_W-1:0] len_sat;
	logic [urb_pkg::RX_CW-1:0]  rx_fill_nx;
	logic [urb_pkg::TX_CW-1:0]  tx_fill_nx;
	logic                       tx_en_nx;
	logic                       load;
	urb_pkg::res_t              res;

	assign rx_full  = (rx_fill_q == urb_pkg::RX_CW'(urb_pkg::RX_DEPTH));
	assign rx_empty = (rx_fill_q == '0);
	assign tx_full  = (tx_fill_q == urb_pkg::TX_CW'(urb_pkg::TX_DEPTH));
	assign tx_empty = (tx_fill_q == '0);

	assign in_stall = !((state_q == ST_IDLE) && slot_free);
	assign accept   = in_valid && !in_stall;

	assign len_sat = (read_length > urb_pkg::RLEN_W'(urb_pkg::READ_MAX)) ?
		urb_pkg::RLEN_W'(urb_pkg::READ_MAX) : read_length;
	assign read_last = (rem_q == urb_pkg::REM_W'(1)) || (rx_fill_q == urb_pkg::RX_CW'(1));

	always_comb begin
		rx_push    = 1'b0;
		rx_pop     = 1'b0;
		tx_push    = 1'b0;
		tx_pop     = 1'b0;
		start_read = 1'b0;
		tx_en_nx   = tx_en_q;
		load       = 1'b0;
		res.rkind   = urb_pkg::RES_ACK;
		res.src     = urb_pkg::SRC_NONE;
		res.last    = 1'b1;
		res.dropped = 1'b0;
		res.idle    = 1'b0;
		if (state_q == ST_READ) begin
			if (slot_free) begin
				rx_pop    = 1'b1;
				load      = 1'b1;
				res.rkind = urb_pkg::RES_TO_SW;
				res.src   = urb_pkg::SRC_RX;
				res.last  = read_last;
			end
		end else if (accept) begin
			load = 1'b1;
			case (kind)
				urb_pkg::KIND_LINE_BYTE: begin
					rx_push     = !rx_full;
					res.dropped = rx_full;
				end
				urb_pkg::KIND_READ_REQ: begin
					// nothing to return: plain acknowledgement
					if (len_sat != '0 && !rx_empty) begin
						start_read = 1'b1;
						load       = 1'b0;
					end
				end
				urb_pkg::KIND_WRITE: begin
					tx_push     = !tx_full;
					res.dropped = tx_full;
					tx_en_nx    = 1'b1;
				end
				urb_pkg::KIND_TX_READY: begin
					if (!tx_empty) begin
						tx_pop    = 1'b1;
						res.rkind = urb_pkg::RES_TO_LINE;
						res.src   = urb_pkg::SRC_TX;
					end else begin
						tx_en_nx = 1'b0;
					end
				end
				urb_pkg::KIND_LINE_IDLE: res.idle = 1'b1;
				default: ;
			endcase
		end
		rx_fill_nx = rx_fill_q + urb_pkg::RX_CW'(rx_push) - urb_pkg::RX_CW'(rx_pop);
		tx_fill_nx = tx_fill_q + urb_pkg::TX_CW'(tx_push) - urb_pkg::TX_CW'(tx_pop);
		res.rx_level = urb_pkg::LVL_W'(rx_fill_nx);
		res.tx_level = urb_pkg::LVL_W'(tx_fill_nx);
		res.tx_en    = tx_en_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rx_wr_q   <= '0;
			rx_rd_q   <= '0;
			rx_fill_q <= '0;
			tx_wr_q   <= '0;
			tx_rd_q   <= '0;
			tx_fill_q <= '0;
			tx_en_q   <= 1'b0;
			rem_q     <= '0;
		end else begin
			rx_fill_q <= rx_fill_nx;
			tx_fill_q <= tx_fill_nx;
			tx_en_q   <= tx_en_nx;
			if (rx_push)
				rx_wr_q <= (rx_wr_q == urb_pkg::RX_AW'(urb_pkg::RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
			if (rx_pop)
				rx_rd_q <= (rx_rd_q == urb_pkg::RX_AW'(urb_pkg::RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
			if (tx_push)
				tx_wr_q <= (tx_wr_q == urb_pkg::TX_AW'(urb_pkg::TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
			if (tx_pop)
				tx_rd_q <= (tx_rd_q == urb_pkg::TX_AW'(urb_pkg::TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (start_read) begin
						state_q <= ST_READ;
						rem_q   <= urb_pkg::REM_W'(len_sat);
					end
				end
				ST_READ: begin
					if (rx_pop) begin
						rem_q <= rem_q - 1'b1;
						if (read_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// one item at a time: a write and a read never hit a memory in the same cycle,
	// so a pop issued after a push sees the pushed byte
	always_ff @(posedge clk) begin
		if (rx_push)
			rx_mem[rx_wr_q] <= data;
		if (rx_pop)
			rx_rdata_q <= rx_mem[rx_rd_q];
	end

	always_ff @(posedge clk) begin
		if (tx_push)
			tx_mem[tx_wr_q] <= data;
		if (tx_pop)
			tx_rdata_q <= tx_mem[tx_rd_q];
	end

	urb_out_pipe u_out_pipe (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.res             (res),
		.rx_rdata        (rx_rdata_q),
		.tx_rdata        (tx_rdata_q),
		.slot_free       (slot_free),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.byte_out        (byte_out),
		.last            (last),
		.dropped         (dropped),
		.line_idle       (line_idle),
		.rx_level        (rx_level),
		.tx_level        (tx_level),
		.transmit_enable (transmit_enable)
	);

`ifndef ASSERT_OFF
	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= urb_pkg::RX_CW'(urb_pkg::RX_DEPTH) &&
		tx_fill_q <= urb_pkg::TX_CW'(urb_pkg::TX_DEPTH))
		else $error("ring fill count beyond depth");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> rem_q != '0 && rx_fill_q != '0)
		else $error("read burst running with nothing left to return");

	a_pop_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		rx_pop |-> state_q == ST_READ && !accept)
		else $error("receive pop outside a read burst");

	a_tx_write_sets_en: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == urb_pkg::KIND_WRITE |=> tx_en_q)
		else $error("write beat did not set transmit enable");
`endif

endmodule
